[hdl/mac_address_text_validator_core_assert.svh]
// Assertion macros used by the RTL of the MAC address text validator.
`ifndef MAC_ADDRESS_TEXT_VALIDATOR_CORE_ASSERT_SVH
`define MAC_ADDRESS_TEXT_VALIDATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAVC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAVC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mavc_pkg.sv]
package mavc_pkg;

    localparam int unsigned CNT_W = 5;
    localparam int unsigned RUN_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [RUN_W-1:0] RUN_MAX    = {RUN_W{1'b1}};
    localparam logic [CNT_W-1:0] MIN_CHARS  = CNT_W'(6);
    localparam logic [CNT_W-1:0] MAX_CHARS  = CNT_W'(17);
    localparam logic [CNT_W-1:0] MIN_DIGITS = CNT_W'(6);
    localparam logic [CNT_W-1:0] MAX_DIGITS = CNT_W'(12);
    localparam logic [CNT_W-1:0] MAX_SEPS   = CNT_W'(5);
    localparam logic [RUN_W-1:0] GROUPS     = RUN_W'(5);
    localparam logic [RUN_W-1:0] PAIR_RUN   = RUN_W'(2);
    localparam logic [RUN_W-1:0] SPLIT_RUN  = RUN_W'(6);

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_LONG      = 3'd2,
        ST_BAD_CHAR  = 3'd3,
        ST_FEW_DIG   = 3'd4,
        ST_MANY_DIG  = 3'd5,
        ST_MANY_SEP  = 3'd6,
        ST_NO_FORMAT = 3'd7
    } status_t;

    typedef struct packed {
        logic fire;
        logic last;
    } step_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

endpackage

[hdl/mavc_track.sv]
module mavc_track
(
    input  logic              clk,
    input  logic              rst_n,
    input  mavc_pkg::step_t   step,
    input  logic [7:0]        ch,
    output mavc_pkg::status_t status
);

    localparam logic [mavc_pkg::RUN_W-1:0] RUN_ONE = mavc_pkg::RUN_W'(1);

    logic [mavc_pkg::CNT_W-1:0] char_count_reg, char_count_next;
    logic [mavc_pkg::CNT_W-1:0] digit_count_reg, digit_count_next;
    logic [mavc_pkg::CNT_W-1:0] sep_count_reg, sep_count_next;
    logic                       bad_seen_reg, bad_seen_next;
    logic [mavc_pkg::RUN_W-1:0] run_len_reg, run_len_next;
    logic [mavc_pkg::RUN_W-1:0] group_count_reg, group_count_next;
    logic                       colon_alive_reg, colon_alive_next;
    logic                       dash_alive_reg, dash_alive_next;
    logic                       split_alive_reg, split_alive_next;
    logic                       is_sep;
    logic                       run_pair;

    assign is_sep = (ch == mavc_pkg::CH_DOT) || (ch == mavc_pkg::CH_DASH)
                    || (ch == mavc_pkg::CH_COLON);
    assign run_pair = (run_len_reg != '0) && (run_len_reg <= mavc_pkg::PAIR_RUN);

    always_comb
    begin
        char_count_next  = (char_count_reg == mavc_pkg::CNT_MAX) ? char_count_reg
                                                                  : char_count_reg + 1'b1;
        digit_count_next = digit_count_reg;
        sep_count_next   = sep_count_reg;
        bad_seen_next    = bad_seen_reg;
        run_len_next     = run_len_reg;
        group_count_next = group_count_reg;
        colon_alive_next = colon_alive_reg;
        dash_alive_next  = dash_alive_reg;
        split_alive_next = split_alive_reg;
        if (mavc_pkg::is_hex(ch))
        begin
            if (digit_count_reg != mavc_pkg::CNT_MAX)
            begin
                digit_count_next = digit_count_reg + 1'b1;
            end
            if (run_len_reg >= mavc_pkg::PAIR_RUN)
            begin
                colon_alive_next = 1'b0;
                dash_alive_next  = 1'b0;
            end
            if (run_len_reg >= mavc_pkg::SPLIT_RUN)
            begin
                split_alive_next = 1'b0;
            end
            if (run_len_reg != mavc_pkg::RUN_MAX)
            begin
                run_len_next = run_len_reg + 1'b1;
            end
        end
        else if (is_sep)
        begin
            if (sep_count_reg != mavc_pkg::CNT_MAX)
            begin
                sep_count_next = sep_count_reg + 1'b1;
            end
            colon_alive_next = colon_alive_reg && (ch == mavc_pkg::CH_COLON) && run_pair
                               && (group_count_reg < mavc_pkg::GROUPS);
            dash_alive_next  = dash_alive_reg && (ch == mavc_pkg::CH_DASH)
                               && (run_len_reg == mavc_pkg::PAIR_RUN)
                               && (group_count_reg < mavc_pkg::GROUPS);
            split_alive_next = split_alive_reg && (ch == mavc_pkg::CH_DASH)
                               && (run_len_reg == mavc_pkg::SPLIT_RUN)
                               && (group_count_reg == '0);
            if (group_count_reg != mavc_pkg::RUN_MAX)
            begin
                group_count_next = group_count_reg + 1'b1;
            end
            run_len_next = '0;
        end
        else
        begin
            bad_seen_next    = 1'b1;
            colon_alive_next = 1'b0;
            dash_alive_next  = 1'b0;
            split_alive_next = 1'b0;
        end
    end

    always_comb
    begin
        if (char_count_next < mavc_pkg::MIN_CHARS)
        begin
            status = mavc_pkg::ST_SHORT;
        end
        else if (char_count_next > mavc_pkg::MAX_CHARS)
        begin
            status = mavc_pkg::ST_LONG;
        end
        else if (bad_seen_next)
        begin
            status = mavc_pkg::ST_BAD_CHAR;
        end
        else if (digit_count_next < mavc_pkg::MIN_DIGITS)
        begin
            status = mavc_pkg::ST_FEW_DIG;
        end
        else if (digit_count_next > mavc_pkg::MAX_DIGITS)
        begin
            status = mavc_pkg::ST_MANY_DIG;
        end
        else if (sep_count_next > mavc_pkg::MAX_SEPS)
        begin
            status = mavc_pkg::ST_MANY_SEP;
        end
        else if ((digit_count_next == mavc_pkg::MAX_DIGITS) && (sep_count_next == '0))
        begin
            status = mavc_pkg::ST_OK;
        end
        else if (colon_alive_next && (group_count_next == mavc_pkg::GROUPS)
                 && (run_len_next != '0) && (run_len_next <= mavc_pkg::PAIR_RUN))
        begin
            status = mavc_pkg::ST_OK;
        end
        else if (dash_alive_next && (group_count_next == mavc_pkg::GROUPS)
                 && (run_len_next == mavc_pkg::PAIR_RUN))
        begin
            status = mavc_pkg::ST_OK;
        end
        else if (split_alive_next && (group_count_next == RUN_ONE)
                 && (run_len_next == mavc_pkg::SPLIT_RUN))
        begin
            status = mavc_pkg::ST_OK;
        end
        else
        begin
            status = mavc_pkg::ST_NO_FORMAT;
        end
    end

    // The trackers return to their reset values after the last character of a text.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg  <= '0;
            digit_count_reg <= '0;
            sep_count_reg   <= '0;
            bad_seen_reg    <= 1'b0;
            run_len_reg     <= '0;
            group_count_reg <= '0;
            colon_alive_reg <= 1'b1;
            dash_alive_reg  <= 1'b1;
            split_alive_reg <= 1'b1;
        end
        else if (step.fire)
        begin
            if (step.last)
            begin
                char_count_reg  <= '0;
                digit_count_reg <= '0;
                sep_count_reg   <= '0;
                bad_seen_reg    <= 1'b0;
                run_len_reg     <= '0;
                group_count_reg <= '0;
                colon_alive_reg <= 1'b1;
                dash_alive_reg  <= 1'b1;
                split_alive_reg <= 1'b1;
            end
            else
            begin
                char_count_reg  <= char_count_next;
                digit_count_reg <= digit_count_next;
                sep_count_reg   <= sep_count_next;
                bad_seen_reg    <= bad_seen_next;
                run_len_reg     <= run_len_next;
                group_count_reg <= group_count_next;
                colon_alive_reg <= colon_alive_next;
                dash_alive_reg  <= dash_alive_next;
                split_alive_reg <= split_alive_next;
            end
        end
    end

endmodule

[hdl/mac_address_text_validator_core.sv]
// MAC address text validator. The text enters one character per transaction on
// ch, with last set on its final character; one status transaction follows each
// text, and characters without last give none. Status 0 means the text is a MAC
// address in one of the accepted layouts: twelve plain hex digits, six colon
// groups of one or two digits, six dash-separated pairs, or six digits, a dash
// and six digits. The other codes report the first failed check in this order:
// too short, too long, bad character, too few digits, too many digits, too many
// separators, no layout matched. A character is registered on input and handled
// from that register by the trackers, which work out a status combinationally,
// so the block takes one character every cycle while no last character waits,
// and a status is registered as the trackers handle its last character. A last
// character waits in the input register while an earlier status has not been
// taken, and the input stalls for as long as it waits.
`include "mac_address_text_validator_core_assert.svh"

module mac_address_text_validator_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status
);

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_ch_reg;
    logic              s1_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg;
    logic              out_free;
    logic              s1_fire;
    logic              in_fire;
    mavc_pkg::step_t   step;
    mavc_pkg::status_t track_status;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    assign step = '{fire: s1_fire, last: s1_last_reg};

    mavc_track u_track
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .ch     (s1_ch_reg),
        .status (track_status)
    );

    always_comb
    begin
        s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);
        if (s1_fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ch_reg   <= ch;
            s1_last_reg <= last;
        end
        if (s1_fire && s1_last_reg)
        begin
            status_reg <= track_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    `MAVC_ASSERT_NEXT(a_last_gives_status, clk, rst_n,
        s1_valid_reg && s1_last_reg && out_free, out_valid,
        "A finished text did not present its status.")
    `MAVC_ASSERT_SAME(a_mid_char_never_stalls, clk, rst_n,
        s1_valid_reg && !s1_last_reg, in_ready && s1_fire,
        "A character inside a text was held back.")
    `MAVC_ASSERT_SAME(a_full_path_blocks_input, clk, rst_n,
        s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready, !in_ready,
        "Input was accepted while a last character was waiting.")

endmodule

[sim/mac_address_text_validator_core_checker.sv]
module mac_address_text_validator_core_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] status,
    output int         mismatches,
    output int         texts_open
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [mavc_pkg::CNT_W-1:0] text_len;
    logic [mavc_pkg::CNT_W-1:0] digit_tally;
    logic [mavc_pkg::CNT_W-1:0] sep_tally;
    logic                       saw_bad;
    logic [mavc_pkg::RUN_W-1:0] digit_run;
    logic [mavc_pkg::RUN_W-1:0] sep_groups;
    logic                       colon_fits;
    logic                       dash_fits;
    logic                       split_fits;

    mavc_pkg::status_t pending_status[$];
    int                fail_count;

    function automatic logic hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    task automatic clear_text();
        text_len    = '0;
        digit_tally = '0;
        sep_tally   = '0;
        saw_bad     = 1'b0;
        digit_run   = '0;
        sep_groups  = '0;
        colon_fits  = 1'b1;
        dash_fits   = 1'b1;
        split_fits  = 1'b1;
    endtask

    // The first failed check decides the status; the layouts are tried last.
    function automatic mavc_pkg::status_t text_verdict();
        if (text_len < mavc_pkg::MIN_CHARS)
            return mavc_pkg::ST_SHORT;
        if (text_len > mavc_pkg::MAX_CHARS)
            return mavc_pkg::ST_LONG;
        if (saw_bad)
            return mavc_pkg::ST_BAD_CHAR;
        if (digit_tally < mavc_pkg::MIN_DIGITS)
            return mavc_pkg::ST_FEW_DIG;
        if (digit_tally > mavc_pkg::MAX_DIGITS)
            return mavc_pkg::ST_MANY_DIG;
        if (sep_tally > mavc_pkg::MAX_SEPS)
            return mavc_pkg::ST_MANY_SEP;
        if (digit_tally == mavc_pkg::MAX_DIGITS && sep_tally == '0)
            return mavc_pkg::ST_OK;
        if (colon_fits && sep_groups == mavc_pkg::GROUPS && digit_run >= 1
            && digit_run <= mavc_pkg::PAIR_RUN)
            return mavc_pkg::ST_OK;
        if (dash_fits && sep_groups == mavc_pkg::GROUPS && digit_run == mavc_pkg::PAIR_RUN)
            return mavc_pkg::ST_OK;
        if (split_fits && sep_groups == 1 && digit_run == mavc_pkg::SPLIT_RUN)
            return mavc_pkg::ST_OK;
        return mavc_pkg::ST_NO_FORMAT;
    endfunction

    task automatic take_char(input logic [7:0] c, input logic fin);
        logic is_sep;
        is_sep = (c == mavc_pkg::CH_DOT) || (c == mavc_pkg::CH_DASH)
                 || (c == mavc_pkg::CH_COLON);
        if (text_len != mavc_pkg::CNT_MAX)
            text_len = text_len + 1'b1;
        if (hex_char(c))
        begin
            if (digit_tally != mavc_pkg::CNT_MAX)
                digit_tally = digit_tally + 1'b1;
            if (digit_run >= mavc_pkg::PAIR_RUN)
            begin
                colon_fits = 1'b0;
                dash_fits  = 1'b0;
            end
            if (digit_run >= mavc_pkg::SPLIT_RUN)
                split_fits = 1'b0;
            if (digit_run != mavc_pkg::RUN_MAX)
                digit_run = digit_run + 1'b1;
        end
        else if (is_sep)
        begin
            if (sep_tally != mavc_pkg::CNT_MAX)
                sep_tally = sep_tally + 1'b1;
            colon_fits = colon_fits && c == mavc_pkg::CH_COLON && digit_run >= 1 &&
                         digit_run <= mavc_pkg::PAIR_RUN && sep_groups < mavc_pkg::GROUPS;
            dash_fits  = dash_fits && c == mavc_pkg::CH_DASH &&
                         digit_run == mavc_pkg::PAIR_RUN && sep_groups < mavc_pkg::GROUPS;
            split_fits = split_fits && c == mavc_pkg::CH_DASH &&
                         digit_run == mavc_pkg::SPLIT_RUN && sep_groups == '0;
            if (sep_groups != mavc_pkg::RUN_MAX)
                sep_groups = sep_groups + 1'b1;
            digit_run = '0;
        end
        else
        begin
            saw_bad    = 1'b1;
            colon_fits = 1'b0;
            dash_fits  = 1'b0;
            split_fits = 1'b0;
        end
        if (fin)
        begin
            pending_status.push_back(text_verdict());
            clear_text();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mavc_pkg::status_t want;
        if (!rst_n)
        begin
            clear_text();
            pending_status.delete();
            fail_count = 0;
            mismatches <= 0;
            texts_open <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_status.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected status, expected none, actual %0d",
                             $time, status);
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (status !== want)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                                 $time, want, want.name(), status);
                    end
                end
            end
            if (in_valid && in_ready)
                take_char(ch, last);
            texts_open <= pending_status.size();
            mismatches <= fail_count;
        end
    end

endmodule

[sim/tb_mac_address_text_validator_core.sv]
module tb_mac_address_text_validator_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] text_t[$];

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 800;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] ch        = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;

    int       mismatches;
    int       texts_open;
    int       burst_left  = 0;
    int       chars_sent  = 0;
    int       idle_cycles = 0;
    int       rx_tick     = 0;
    rx_mode_t rx_mode     = RX_OPEN;

    mac_address_text_validator_core dut (.*);

    mac_address_text_validator_core_checker status_monitor (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 97 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
            default:   out_ready <= (rx_tick % 6 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_sep();
        case ($urandom_range(0, 2))
            0:       return mavc_pkg::CH_COLON;
            1:       return mavc_pkg::CH_DASH;
            default: return mavc_pkg::CH_DOT;
        endcase
    endfunction

    // Mostly hex digits and separators, with an occasional arbitrary byte.
    function automatic logic [7:0] rand_mixed();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return rand_hex();
            4, 5, 6:    return rand_sep();
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic text_t to_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    function automatic text_t well_formed(input int kind);
        text_t t;
        case (kind)
            0:
                repeat (12) t.push_back(rand_hex());
            1:
                for (int g = 0; g < 6; g++)
                begin
                    if (g != 0)
                        t.push_back(mavc_pkg::CH_COLON);
                    repeat ($urandom_range(1, 2)) t.push_back(rand_hex());
                end
            2:
                for (int g = 0; g < 6; g++)
                begin
                    if (g != 0)
                        t.push_back(mavc_pkg::CH_DASH);
                    repeat (2) t.push_back(rand_hex());
                end
            default:
            begin
                repeat (6) t.push_back(rand_hex());
                t.push_back(mavc_pkg::CH_DASH);
                repeat (6) t.push_back(rand_hex());
            end
        endcase
        return t;
    endfunction

    function automatic text_t mutate(input text_t t);
        int pos;
        pos = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 4))
            0:       t[pos] = 8'($urandom_range(0, 255));
            1:       if (t.size() > 1) t.delete(pos);
            2:       t.insert(pos, rand_hex());
            3:       t.insert(pos, rand_sep());
            default: t[pos] = rand_sep();
        endcase
        return t;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last     <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
    endtask

    initial
    begin
        text_t t;
        int    pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_text(to_text("A"));
        send_text(to_text("0123456789abcdef01"));
        send_text(to_text("01234G6789ab"));
        send_text(to_text("1:2:3:4"));
        send_text(to_text("0123456789abcd"));
        send_text(to_text("1:2:3:4:5:6:7"));
        send_text(to_text("0123456789AB"));
        send_text(to_text("0:1a:B:22:3:f"));
        send_text(to_text("00-1A-2b-3C-4d-5E"));
        send_text(to_text("a1b2c3-D4E5F6"));
        send_text(to_text("00.11.22.33.44.55"));
        send_text(to_text("00:11-22:33:44:55"));
        t = to_text("0123");
        t.push_back(8'h00);
        t.push_back(8'h80);
        t.push_back(8'hFF);
        t.push_back("9");
        send_text(t);
        t = {};
        repeat (40) t.push_back(rand_hex());
        send_text(t);
        send_text(to_text("1:2:3:4:5:6:7:8:9:0"));

        while (chars_sent < RANDOM_CHARS)
        begin
            t = {};
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                t = well_formed(pick % 4);
                if ($urandom_range(0, 3) == 0)
                    t = mutate(t);
                if ($urandom_range(0, 9) == 0)
                    t = mutate(t);
            end
            else if (pick < 15)
            begin
                repeat ($urandom_range(1, 18)) t.push_back(rand_mixed());
            end
            else if (pick < 17)
            begin
                t = well_formed($urandom_range(1, 3));
                foreach (t[i])
                    if (t[i] == mavc_pkg::CH_COLON || t[i] == mavc_pkg::CH_DASH)
                        t[i] = rand_sep();
            end
            else if (pick < 19)
            begin
                repeat ($urandom_range(1, 20)) t.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(18, 40)) t.push_back(rand_mixed());
            end
            send_text(t);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (texts_open != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
